[rtl/assert_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/mbhr_pkg.sv]
// types and constants for the holding register server
// no dependencies
package mbhr_pkg;
  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       frame_last;
    logic       frame_empty;
  } req_word_t;

  typedef struct packed {
    logic [7:0] resp_byte0;
    logic [7:0] resp_byte1;
    logic [7:0] resp_byte2;
    logic [7:0] resp_byte3;
    logic [2:0] valid_bytes;
    logic       resp_last;
    logic       resp_status;
  } resp_word_t;

  localparam logic [7:0] FC_READ       = 8'd3;
  localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
  localparam logic [7:0] FC_WRITE_MANY = 8'd16;
  localparam logic [7:0] EXC_FUNCTION  = 8'd1;
  localparam logic [7:0] EXC_ADDRESS   = 8'd2;
  localparam logic [7:0] EXC_VALUE     = 8'd3;
  localparam logic [15:0] READ_MAX     = 16'd125;
  localparam logic [15:0] WRITE_MAX    = 16'd123;
  localparam logic [15:0] FIXED_LEN    = 16'd5;
  localparam logic [15:0] HEADER_LEN   = 16'd6;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_RECV, ST_CHECK, ST_HDR, ST_RD_REQ, ST_RD_WAIT,
    ST_EMIT, ST_COMMIT, ST_WRITE1, ST_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    RK_EXC, RK_ECHO, RK_READ
  } resp_kind_t;

  // controller commands to datapath
  typedef struct packed {
    logic take;        // absorb a request byte
    logic clr_frame;   // drop frame fields
    logic clr_step;    // clear memory sweep / pointer
    logic clr_write;   // write zero at sweep pointer
    logic step_inc;    // advance sweep/index
    logic rd_issue;    // read register at addr+index
    logic rd_latch;    // latch read data into byte buffer
    logic hdr_load;    // load response header bytes
    logic emit_pop;    // response word taken
    logic wr_one;      // single write
    logic wr_stage;    // copy staged word
    logic empty_load;  // load empty-status word
  } cmd_t;

  typedef struct packed {
    logic       step_done;  // commit index at its end
    logic       clr_done;
    logic       resp_done;  // last response word is in the buffer
    logic       buf_need;   // byte buffer wants another register word
    resp_kind_t kind;       // outcome of checks
  } stat_t;
endpackage

[rtl/mbhr_ctrl.sv]
// controller state machine of the holding register server
// depends on mbhr_pkg
module mbhr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              in_empty,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mbhr_pkg::stat_t   st,
  output mbhr_pkg::cmd_t    cmd
);
  mbhr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mbhr_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      mbhr_pkg::ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        cmd.step_inc = 1'b1;
        if (st.clr_done) begin
          cmd.clr_step = 1'b1;
          state_next = mbhr_pkg::ST_RECV;
        end
      end
      mbhr_pkg::ST_RECV: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_empty) begin
            cmd.clr_frame = 1'b1;
            cmd.empty_load = 1'b1;
            state_next = mbhr_pkg::ST_EMPTY;
          end else begin
            cmd.take = 1'b1;
            if (in_last) state_next = mbhr_pkg::ST_CHECK;
          end
        end
      end
      mbhr_pkg::ST_CHECK: begin
        // check outcome comes straight from the datapath, which also registers it
        cmd.clr_step = 1'b1;
        state_next = mbhr_pkg::ST_HDR;
        if (st.kind == mbhr_pkg::RK_ECHO) begin
          state_next = mbhr_pkg::ST_COMMIT;
        end
      end
      mbhr_pkg::ST_COMMIT: begin
        // single write or staged copy, then header
        cmd.wr_one = 1'b1;
        cmd.wr_stage = 1'b1;
        cmd.step_inc = 1'b1;
        if (st.step_done) begin
          cmd.clr_step = 1'b1;
          state_next = mbhr_pkg::ST_HDR;
        end
      end
      mbhr_pkg::ST_HDR: begin
        cmd.hdr_load = 1'b1;
        state_next = mbhr_pkg::ST_EMIT;
      end
      mbhr_pkg::ST_RD_REQ: begin
        cmd.rd_issue = 1'b1;
        state_next = mbhr_pkg::ST_RD_WAIT;
      end
      mbhr_pkg::ST_RD_WAIT: begin
        cmd.rd_latch = 1'b1;
        cmd.step_inc = 1'b1;
        state_next = mbhr_pkg::ST_EMIT;
      end
      mbhr_pkg::ST_EMIT: begin
        if (st.buf_need) begin
          state_next = mbhr_pkg::ST_RD_REQ;
        end else begin
          out_valid = 1'b1;
          if (!out_stall) begin
            cmd.emit_pop = 1'b1;
            if (st.resp_done) begin
              cmd.clr_frame = 1'b1;
              state_next = mbhr_pkg::ST_RECV;
            end
          end
        end
      end
      mbhr_pkg::ST_EMPTY: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = mbhr_pkg::ST_RECV;
      end
      mbhr_pkg::ST_WRITE1: state_next = mbhr_pkg::ST_RECV;
      default: state_next = mbhr_pkg::ST_RECV;
    endcase
  end
endmodule

[rtl/mbhr_dp.sv]
// datapath: request fields, staging memory, register memory, response bytes
// depends on mbhr_pkg
module mbhr_dp #(
  parameter int MAP_DEPTH = 1024,
  parameter int STAGE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           pdu_byte,
  input  mbhr_pkg::cmd_t       cmd,
  output mbhr_pkg::stat_t      st,
  output mbhr_pkg::resp_word_t resp
);
  localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SW = $clog2(STAGE_DEPTH);

  logic [15:0] hreg [MAP_DEPTH];
  logic [15:0] stage [STAGE_DEPTH];
  logic [15:0] stage_rd;      // staged word for the next commit step

  logic [7:0]  req_function;
  logic [15:0] req_address, req_quantity;
  logic [7:0]  req_byte_count;
  logic [15:0] byte_position;
  logic [7:0]  pending_high_byte;
  logic [16:0] step;          // sweep / commit / read index
  logic [16:0] step_next;
  mbhr_pkg::resp_kind_t kind;
  logic [7:0]  exc_code;

  // response: 5-byte buffer of pending bytes, count of bytes still to send
  logic [7:0]  rbuf [5];
  logic [2:0]  rcnt;          // bytes in buffer
  logic [8:0]  remain;        // bytes not yet moved into buffer
  logic [15:0] rd_data;

  // request field capture
  logic [15:0] dpos;
  assign dpos = byte_position - mbhr_pkg::HEADER_LEN;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_frame) begin
      req_function <= '0;
      req_address <= '0;
      req_quantity <= '0;
      req_byte_count <= '0;
      byte_position <= '0;
      pending_high_byte <= '0;
    end else if (cmd.take) begin
      if (byte_position == 16'd0) req_function <= pdu_byte;
      else if (byte_position <= 16'd2) req_address <= {req_address[7:0], pdu_byte};
      else if (byte_position <= 16'd4) req_quantity <= {req_quantity[7:0], pdu_byte};
      else if (byte_position == 16'd5) req_byte_count <= pdu_byte;
      else if (!dpos[0]) pending_high_byte <= pdu_byte;
      if (byte_position != 16'hFFFF) byte_position <= byte_position + 16'd1;
    end
  end

  // staging memory, read one step ahead so the commit sees registered data
  always_ff @(posedge clk) begin
    if (cmd.take && byte_position >= mbhr_pkg::HEADER_LEN && dpos[0]
        && dpos[15:1] < 15'(STAGE_DEPTH))
      stage[dpos[SW:1]] <= {pending_high_byte, pdu_byte};
    stage_rd <= stage[step_next[SW-1:0]];
  end

  // checks, evaluated combinationally and registered in the CHECK state
  logic [16:0] addr_end;
  logic        len5, qty_rd_ok, qty_wr_ok, rng_ok, bc_ok;
  mbhr_pkg::resp_kind_t kind_c;
  logic [7:0]  code_c;
  assign addr_end = {1'b0, req_address} + {1'b0, req_quantity};
  assign len5 = byte_position == mbhr_pkg::FIXED_LEN;
  assign qty_rd_ok = req_quantity >= 16'd1 && req_quantity <= mbhr_pkg::READ_MAX;
  assign qty_wr_ok = req_quantity >= 16'd1 && req_quantity <= mbhr_pkg::WRITE_MAX;
  assign rng_ok = addr_end <= 17'(MAP_DEPTH);
  assign bc_ok = {8'd0, req_byte_count} == {req_quantity[14:0], 1'b0}
                 && !req_quantity[15]
                 && byte_position == mbhr_pkg::HEADER_LEN + {8'd0, req_byte_count};

  always_comb begin
    kind_c = mbhr_pkg::RK_EXC;
    code_c = mbhr_pkg::EXC_FUNCTION;
    unique case (req_function)
      mbhr_pkg::FC_READ: begin
        if (!len5 || !qty_rd_ok) code_c = mbhr_pkg::EXC_VALUE;
        else if (!rng_ok) code_c = mbhr_pkg::EXC_ADDRESS;
        else kind_c = mbhr_pkg::RK_READ;
      end
      mbhr_pkg::FC_WRITE_ONE: begin
        if (!len5) code_c = mbhr_pkg::EXC_VALUE;
        else if ({1'b0, req_address} >= 17'(MAP_DEPTH)) code_c = mbhr_pkg::EXC_ADDRESS;
        else kind_c = mbhr_pkg::RK_ECHO;
      end
      mbhr_pkg::FC_WRITE_MANY: begin
        if (byte_position < mbhr_pkg::HEADER_LEN || !bc_ok || !qty_wr_ok)
          code_c = mbhr_pkg::EXC_VALUE;
        else if (!rng_ok) code_c = mbhr_pkg::EXC_ADDRESS;
        else kind_c = mbhr_pkg::RK_ECHO;
      end
      default: ;
    endcase
  end

  // check results are taken in the cycle after the last byte (CHECK state)
  always_ff @(posedge clk) begin
    if (cmd.clr_step && !cmd.hdr_load) begin
      kind <= kind_c;
      exc_code <= code_c;
    end
  end

  // single-write vs multi-write counts
  logic is_one;
  logic [16:0] commit_len;
  assign is_one = req_function == mbhr_pkg::FC_WRITE_ONE;
  assign commit_len = is_one ? 17'd1 : {1'b0, req_quantity};

  // step counter
  always_comb begin
    if (rst || cmd.clr_step) step_next = '0;
    else if (cmd.step_inc) step_next = step + 17'd1;
    else step_next = step;
  end

  always_ff @(posedge clk) begin
    step <= step_next;
  end

  logic [AW-1:0] maddr;
  logic [16:0]   aidx;
  assign aidx = {1'b0, req_address} + step;
  assign maddr = cmd.clr_write ? step[AW-1:0] : aidx[AW-1:0];

  // register memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_write)
      hreg[maddr] <= '0;
    else if (kind == mbhr_pkg::RK_ECHO) begin
      if (cmd.wr_one && is_one) hreg[maddr] <= req_quantity;
      else if (cmd.wr_stage && !is_one) hreg[maddr] <= stage_rd;
    end
    if (cmd.rd_issue) rd_data <= hreg[maddr];
  end

  // response byte buffer
  always_ff @(posedge clk) begin
    if (cmd.hdr_load) begin
      rbuf[0] <= (kind == mbhr_pkg::RK_EXC) ? (req_function | 8'h80) : req_function;
      if (kind == mbhr_pkg::RK_EXC) begin
        rbuf[1] <= exc_code;
        rcnt <= 3'd2;
        remain <= '0;
      end else if (kind == mbhr_pkg::RK_READ) begin
        rbuf[1] <= {req_quantity[6:0], 1'b0};
        rcnt <= 3'd2;
        remain <= {req_quantity[7:0], 1'b0};
      end else begin
        rbuf[1] <= req_address[15:8];
        rbuf[2] <= req_address[7:0];
        rbuf[3] <= req_quantity[15:8];
        rbuf[4] <= req_quantity[7:0];
        rcnt <= 3'd5;
        remain <= '0;
      end
    end else if (cmd.rd_latch) begin
      rbuf[rcnt] <= rd_data[15:8];
      rbuf[rcnt + 3'd1] <= rd_data[7:0];
      rcnt <= rcnt + 3'd2;
      remain <= remain - 9'd2;
    end else if (cmd.emit_pop) begin
      rbuf[0] <= rbuf[4];
      rcnt <= (rcnt > 3'd4) ? rcnt - 3'd4 : 3'd0;
    end
  end

  always_comb begin
    resp = '0;
    if (cmd.empty_load || rcnt == 3'd7) begin
      resp = '0;
    end
    resp.valid_bytes = (rcnt > 3'd4) ? 3'd4 : rcnt;
    resp.resp_byte0 = (rcnt > 3'd0) ? rbuf[0] : 8'd0;
    resp.resp_byte1 = (rcnt > 3'd1) ? rbuf[1] : 8'd0;
    resp.resp_byte2 = (rcnt > 3'd2) ? rbuf[2] : 8'd0;
    resp.resp_byte3 = (rcnt > 3'd3) ? rbuf[3] : 8'd0;
    resp.resp_last = (rcnt <= 3'd4) && (remain == 9'd0);
    resp.resp_status = 1'b0;
  end

  always_comb begin
    st.kind = kind_c;
    st.clr_done = step == 17'(MAP_DEPTH - 1);
    st.step_done = kind != mbhr_pkg::RK_ECHO || step + 17'd1 >= commit_len;
    st.resp_done = (rcnt <= 3'd4) && (remain == 9'd0);
    st.buf_need = (rcnt < 3'd4) && (remain != 9'd0);
  end
endmodule

[rtl/modbus_holding_register_server.sv]
// top level of the modbus holding register server
// depends on mbhr_pkg, mbhr_ctrl, mbhr_dp
//
// request channel: one pdu byte per word, frame_last on the final byte,
//   frame_empty marks a request that ended with no bytes
// response channel: up to four response bytes per word, valid_bytes gives
//   how many lead bytes count, resp_last marks the final word
// throughput: request bytes are taken one per cycle until the last byte;
//   the request side then stalls until the final response word is taken
// sequence: after the last byte a check state, then a commit of one
//   register per cycle for writes, then a header state; each register a
//   read returns passes a buffer check, an address and a data state, and
//   each response word is sent from the emit state, which also waits on
//   the stalls of the receiver
// an empty request answers with one word of status 1 and no bytes
// reset: the register memory is swept to zero, one register per cycle,
//   all MAP_DEPTH registers, while the request side is stalled
// a receiver stall holds the response word stable and pauses the block
module modbus_holding_register_server #(
  parameter int MAP_DEPTH = 1024,
  parameter int STAGE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mbhr_pkg::req_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mbhr_pkg::resp_word_t out_data
);
  mbhr_pkg::cmd_t       cmd;
  mbhr_pkg::stat_t      st;
  mbhr_pkg::resp_word_t dp_resp;
  logic                 empty_pend;   // empty-request status word pending

  mbhr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_last(in_data.frame_last), .in_empty(in_data.frame_empty),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .st(st), .cmd(cmd)
  );

  mbhr_dp #(.MAP_DEPTH(MAP_DEPTH), .STAGE_DEPTH(STAGE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .pdu_byte(in_data.pdu_byte),
    .cmd(cmd), .st(st), .resp(dp_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) empty_pend <= 1'b0;
    else if (cmd.empty_load) empty_pend <= 1'b1;
    else if (out_valid && !out_stall) empty_pend <= 1'b0;
  end

  always_comb begin
    out_data = dp_resp;
    if (empty_pend) begin
      out_data = '0;
      out_data.resp_last = 1'b1;
      out_data.resp_status = 1'b1;
    end
  end
endmodule

[rtl/mbhr_checker.sv]
// port-level checks for the holding register server
// depends on mbhr_pkg and assert_macros.svh
`include "assert_macros.svh"
module mbhr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mbhr_pkg::resp_word_t out_data
);
  `ASSERT_IMPLY(a_bytes_max, clk, rst, out_valid, out_data.valid_bytes <= 3'd4)
  `ASSERT_IMPLY(a_status_last, clk, rst, out_valid && out_data.resp_status,
                out_data.resp_last && out_data.valid_bytes == 3'd0)
  `ASSERT_IMPLY(a_no_overlap, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

bind modbus_holding_register_server mbhr_checker u_mbhr_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
